// ----- hdl/unix_seconds_to_civil_date_assert.svh -----
// ----------------------------------------------------------------------------
// unix seconds to civil date: assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef UNIX_SECONDS_TO_CIVIL_DATE_ASSERT_SVH
`define UNIX_SECONDS_TO_CIVIL_DATE_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, off while reset is applied
`define USCD_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, live through reset too
`define USCD_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define USCD_ASSERT_RST(label, clk, rst_n, prop, msg)
`define USCD_ASSERT(label, clk, prop, msg)
`endif
`endif

// ----- hdl/uscd_pkg.sv -----
// ----------------------------------------------------------------------------
// uscd_pkg
// types, divider reciprocals and calendar constants of the date converter
// ----------------------------------------------------------------------------
package uscd_pkg;

  // transaction payloads
  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [9:0]  millis_in;
  } in_t;

  typedef struct packed {
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [9:0]  millis_out;
  } out_t;

  // one pipeline stage worth of working values
  typedef struct packed {
    logic [31:0] secs;
    logic [9:0]  ms;
    logic [50:0] dprod;
    logic [31:0] rq;
    logic [15:0] days;
    logic [16:0] sod;
    logic [29:0] tprod;
    logic [4:0]  hour;
    logic [11:0] soh;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        era_hi;
    logic [17:0] doe;
    logic [1:0]  cc;
    logic [6:0]  nq;
    logic [17:0] num;
    logic [8:0]  yoe;
    logic [11:0] yr;
    logic [8:0]  doy;
    logic [3:0]  mp;
  } pipe_t;

  localparam int NumStages = 11;

  localparam logic [9:0]  MsMax    = 10'd999;
  localparam logic [16:0] DaySecs  = 17'd86400;
  localparam logic [11:0] HourSecs = 12'd3600;
  localparam logic [5:0]  MinSecs  = 6'd60;

  // floor reciprocals, quotient estimate is exact or one low
  localparam int DayShift = 35;
  localparam logic [25:0] DayRcp = 26'((64'd1 << DayShift) / 675);
  localparam int HrShift = 24;
  localparam logic [12:0] HrRcp = 13'((64'd1 << HrShift) / 3600);
  localparam int MinShift = 16;
  localparam logic [10:0] MinRcp = 11'((64'd1 << MinShift) / 60);
  localparam int CycShift = 18;
  localparam logic [7:0]  CycRcp = 8'((64'd1 << CycShift) / 1460);
  localparam int YrShift = 18;
  localparam logic [9:0]  YrRcp = 10'((64'd1 << YrShift) / 365);

  // eras of 400 years starting 1600-03-01 and 2000-03-01
  localparam logic [15:0] EraSplit    = 16'd11017;
  localparam logic [17:0] EraLoOffset = 18'd135080;
  localparam logic [11:0] EraLoYear   = 12'd1600;
  localparam logic [11:0] EraHiYear   = 12'd2000;
  localparam logic [17:0] CentDays1   = 18'd36524;
  localparam logic [17:0] CentDays2   = 18'd73048;
  localparam logic [17:0] CentDays3   = 18'd109572;
  localparam logic [10:0] CycDays     = 11'd1460;
  localparam logic [8:0]  YearDays    = 9'd365;
  localparam logic [3:0]  MarchBasedJan = 4'd10;

  // first day of each month, year starting in march
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/unix_seconds_to_civil_date.sv -----
// ----------------------------------------------------------------------------
// unix_seconds_to_civil_date
// pipelined conversion of unix seconds to gregorian date and time of day
// ----------------------------------------------------------------------------
// usage
//   input: a transaction is taken at each rising edge with start high and
//   busy low; busy never rises, so a new timestamp may enter every cycle
//   output: out_valid is high for exactly one cycle per transaction with the
//   date in out_data; results leave in the order the inputs came in
// throughput and pipeline
//   one transaction per clock cycle, sustained
//   a result passes eleven work stages and the output register before
//   out_valid rises; each constant divide is a reciprocal multiply in one
//   stage and a single compare and correct in a later one, with the day
//   divide putting its back multiply in a stage between the two
// reset
//   rst_n low clears every valid bit, so nothing comes out until new
//   transactions have worked through the pipe; payload is not reset
// back pressure
//   the receiver has no way to hold results off, so nothing stalls
// ----------------------------------------------------------------------------
module unix_seconds_to_civil_date
  import uscd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

`include "unix_seconds_to_civil_date_assert.svh"

  logic                 accept;
  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] vld_nxt;
  logic                 out_valid_r;
  out_t                 out_data_r;
  out_t                 out_nxt;

  pipe_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r, s10_r, s11_r;
  pipe_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt, s8_nxt;
  pipe_t s9_nxt, s10_nxt, s11_nxt;

  // never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: saturate millis, day quotient estimate from seconds / 128 / 675
  always_comb begin
    s1_nxt       = '0;
    s1_nxt.secs  = in_data.unix_seconds;
    s1_nxt.ms    = (in_data.millis_in > MsMax) ? MsMax : in_data.millis_in;
    s1_nxt.dprod = 51'(in_data.unix_seconds[31:7]) * 51'(DayRcp);
  end

  // stage 2: product of the estimate and seconds per day
  always_comb begin
    s2_nxt      = s1_r;
    s2_nxt.days = s1_r.dprod[50:DayShift];
    s2_nxt.rq   = 32'(s1_r.dprod[50:DayShift]) * 32'(DaySecs);
  end

  // stage 3: remainder and correction, days and second of day
  always_comb begin : s3_comb
    logic [31:0] rem;
    rem    = s2_r.secs - s2_r.rq;
    s3_nxt = s2_r;
    if (rem >= 32'(DaySecs)) begin
      s3_nxt.days = s2_r.days + 16'd1;
      s3_nxt.sod  = 17'(rem - 32'(DaySecs));
    end else begin
      s3_nxt.sod  = rem[16:0];
    end
  end

  // stage 4: hour estimate, day of era
  always_comb begin
    s4_nxt        = s3_r;
    s4_nxt.tprod  = 30'(s3_r.sod) * 30'(HrRcp);
    s4_nxt.era_hi = (s3_r.days >= EraSplit);
    if (s3_r.days >= EraSplit) begin
      s4_nxt.doe = 18'(s3_r.days) - 18'(EraSplit);
    end else begin
      s4_nxt.doe = 18'(s3_r.days) + EraLoOffset;
    end
  end

  // stage 5: hour and second of hour; century count, leap cycle estimate
  always_comb begin : s5_comb
    logic [4:0]  hest;
    logic [16:0] hrem;
    hest   = s4_r.tprod[HrShift+4:HrShift];
    hrem   = s4_r.sod - 17'(hest) * 17'(HourSecs);
    s5_nxt = s4_r;
    if (hrem >= 17'(HourSecs)) begin
      s5_nxt.hour = hest + 5'd1;
      s5_nxt.soh  = 12'(hrem - 17'(HourSecs));
    end else begin
      s5_nxt.hour = hest;
      s5_nxt.soh  = hrem[11:0];
    end
    // the last day of the era stays in the third century, the count stops at three
    s5_nxt.cc    = 2'(s4_r.doe >= CentDays1) + 2'(s4_r.doe >= CentDays2)
                 + 2'(s4_r.doe >= CentDays3);
    s5_nxt.dprod = 51'(s4_r.doe) * 51'(CycRcp);
  end

  // stage 6: minute estimate; four year cycles in the era
  always_comb begin : s6_comb
    logic [6:0]  nest;
    logic [17:0] nrem;
    nest         = s5_r.dprod[CycShift+6:CycShift];
    nrem         = s5_r.doe - 18'(nest) * 18'(CycDays);
    s6_nxt       = s5_r;
    s6_nxt.tprod = 30'(s5_r.soh) * 30'(MinRcp);
    s6_nxt.nq    = (nrem >= 18'(CycDays)) ? nest + 7'd1 : nest;
  end

  // stage 7: minute and second; leap corrected day count
  always_comb begin : s7_comb
    logic [5:0]  mest;
    logic [11:0] mrem;
    mest   = s6_r.tprod[MinShift+5:MinShift];
    mrem   = s6_r.soh - 12'(mest) * 12'(MinSecs);
    s7_nxt = s6_r;
    if (mrem >= 12'(MinSecs)) begin
      s7_nxt.minute = mest + 6'd1;
      s7_nxt.second = 6'(mrem - 12'(MinSecs));
    end else begin
      s7_nxt.minute = mest;
      s7_nxt.second = mrem[5:0];
    end
    s7_nxt.num = s6_r.doe + 18'(s6_r.cc) - 18'(s6_r.nq);
  end

  // stage 8: year of era estimate
  always_comb begin
    s8_nxt       = s7_r;
    s8_nxt.dprod = 51'(s7_r.num) * 51'(YrRcp);
  end

  // stage 9: year of era
  always_comb begin : s9_comb
    logic [8:0]  yest;
    logic [17:0] yrem;
    yest       = s8_r.dprod[YrShift+8:YrShift];
    yrem       = s8_r.num - 18'(yest) * 18'(YearDays);
    s9_nxt     = s8_r;
    s9_nxt.yoe = (yrem >= 18'(YearDays)) ? yest + 9'd1 : yest;
  end

  // stage 10: day of march based year, year number
  always_comb begin : s10_comb
    logic [1:0]  cent;
    logic [17:0] ystart;
    cent   = 2'(s9_r.yoe >= 9'd100) + 2'(s9_r.yoe >= 9'd200)
           + 2'(s9_r.yoe >= 9'd300);
    ystart = 18'(s9_r.yoe) * 18'(YearDays) + 18'(s9_r.yoe[8:2]) - 18'(cent);
    s10_nxt     = s9_r;
    s10_nxt.doy = 9'(s9_r.doe - ystart);
    s10_nxt.yr  = (s9_r.era_hi ? EraHiYear : EraLoYear) + 12'(s9_r.yoe);
  end

  // stage 11: month of march based year
  always_comb begin : s11_comb
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 1; k < 12; k++) begin
      cnt = cnt + 4'(s10_r.doy >= month_start(4'(k)));
    end
    s11_nxt    = s10_r;
    s11_nxt.mp = cnt;
  end

  // output: day of month, january and february belong to the next year
  always_comb begin
    out_nxt.cal_day    = 5'(s11_r.doy - month_start(s11_r.mp) + 9'd1);
    if (s11_r.mp >= MarchBasedJan) begin
      out_nxt.cal_month = s11_r.mp - 4'd9;
      out_nxt.cal_year  = s11_r.yr + 12'd1;
    end else begin
      out_nxt.cal_month = s11_r.mp + 4'd3;
      out_nxt.cal_year  = s11_r.yr;
    end
    out_nxt.cal_hour   = s11_r.hour;
    out_nxt.cal_minute = s11_r.minute;
    out_nxt.cal_second = s11_r.second;
    out_nxt.millis_out = s11_r.ms;
  end

  // valid bits travel with the data
  assign vld_nxt = {vld_r[NumStages-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[NumStages-1];
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    s3_r       <= s3_nxt;
    s4_r       <= s4_nxt;
    s5_r       <= s5_nxt;
    s6_r       <= s6_nxt;
    s7_r       <= s7_nxt;
    s8_r       <= s8_nxt;
    s9_r       <= s9_nxt;
    s10_r      <= s10_nxt;
    s11_r      <= s11_nxt;
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every accepted transaction comes out through the stages and the output register
  `USCD_ASSERT_RST(a_latency, clk, rst_n, accept |-> ##12 out_valid, "result missing")
  // no result without an accepted transaction that it belongs to
  `USCD_ASSERT(a_no_spurious, clk, out_valid |-> $past(accept, 12), "spurious result")
  // results stay within the calendar
  `USCD_ASSERT_RST(a_range, clk, rst_n, out_valid |-> (out_data.cal_month >= 4'd1 && out_data.cal_month <= 4'd12 && out_data.cal_day >= 5'd1 && out_data.cal_hour <= 5'd23 && out_data.cal_minute <= 6'd59 && out_data.cal_second <= 6'd59 && out_data.cal_year >= 12'd1970 && out_data.cal_year <= 12'd2106), "calendar field out of range")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for unix_seconds_to_civil_date
// drives timestamps through the converter and checks each date it returns
// in order, field by field, against a predictor written here or a date
// typed in by hand. a short table of calendar corner cases comes first,
// then random timestamps, half near year and month boundaries, under
// several sender idle rates, with a drain of the pipe between phases
// ----------------------------------------------------------------------------
module testbench;
  import uscd_pkg::*;

  // calendar constants of the predictor
  localparam int unsigned SECONDS_PER_DAY    = 86400;
  localparam int unsigned SECONDS_PER_HOUR   = 3600;
  localparam int unsigned SECONDS_PER_MINUTE = 60;
  localparam int unsigned EPOCH_YEAR         = 1970;
  localparam int unsigned LAST_YEAR          = 2106;
  localparam int unsigned MILLIS_CAP         = 999;

  // run control
  localparam int RANDOM_PER_PHASE = 250;
  localparam int NUM_PHASES       = 4;
  localparam int DRAIN_CYCLES     = 24;    // extra wait before the verdict
  localparam int QUIET_LIMIT      = 2000;  // cycles with no transaction at all

  // one row of the directed table: a timestamp, and a date typed in by hand
  // where it is obvious, otherwise the predictor supplies it
  typedef struct {
    in_t  stamp;
    bit   typed;
    out_t want;
  } stamp_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic start     = 1'b0;
  in_t  in_data   = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  // sideband that travels with in_data: a hand-typed expected date
  bit   stim_typed = 1'b0;
  out_t stim_want  = '0;

  out_t       pending_dates[$];   // dates still owed by the pipe, oldest first
  stamp_row_t directed_rows[$];
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  out_t       oldest_date;
  int         phase_idle_pct[NUM_PHASES] = '{0, 72, 0, 38};

  unix_seconds_to_civil_date u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // ------------------------------------------------------------------------
  // calendar predictor
  // ------------------------------------------------------------------------

  // full gregorian rule: every fourth year, but not centuries unless by 400
  function automatic bit has_feb29(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned days_in_year(input int unsigned yr);
    return has_feb29(yr) ? 366 : 365;
  endfunction

  // mon counts from 1 for january
  function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mon);
    case (mon)
      2:          return has_feb29(yr) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  // peel whole years off the day count from 1970, then whole months of that
  // year; what is left is the day of month. time of day comes from the
  // remainder and milliseconds saturate, never carrying into the second
  function automatic out_t civil_date_of(input in_t stamp);
    out_t        d;
    int unsigned days_left;
    int unsigned sec_of_day;
    int unsigned yr;
    int unsigned mon;
    days_left  = stamp.unix_seconds / SECONDS_PER_DAY;
    sec_of_day = stamp.unix_seconds % SECONDS_PER_DAY;
    yr = EPOCH_YEAR;
    while (days_left >= days_in_year(yr)) begin
      days_left -= days_in_year(yr);
      yr++;
    end
    mon = 1;
    while (mon < 12 && days_left >= days_in_month(yr, mon)) begin
      days_left -= days_in_month(yr, mon);
      mon++;
    end
    d.cal_year   = 12'(yr);
    d.cal_month  = 4'(mon);
    d.cal_day    = 5'(days_left + 1);
    d.cal_hour   = 5'(sec_of_day / SECONDS_PER_HOUR);
    d.cal_minute = 6'((sec_of_day % SECONDS_PER_HOUR) / SECONDS_PER_MINUTE);
    d.cal_second = 6'(sec_of_day % SECONDS_PER_MINUTE);
    d.millis_out = (stamp.millis_in > MILLIS_CAP) ? 10'(MILLIS_CAP) : stamp.millis_in;
    return d;
  endfunction

  // ------------------------------------------------------------------------
  // directed table helpers
  // ------------------------------------------------------------------------

  function automatic out_t civil(input int unsigned yr, input int unsigned mon,
                                 input int unsigned day, input int unsigned hr,
                                 input int unsigned mi, input int unsigned sec,
                                 input int unsigned ms);
    out_t d;
    d.cal_year   = 12'(yr);
    d.cal_month  = 4'(mon);
    d.cal_day    = 5'(day);
    d.cal_hour   = 5'(hr);
    d.cal_minute = 6'(mi);
    d.cal_second = 6'(sec);
    d.millis_out = 10'(ms);
    return d;
  endfunction

  function automatic stamp_row_t typed_row(input logic [31:0] secs, input logic [9:0] ms,
                                           input out_t want);
    stamp_row_t r;
    r.stamp.unix_seconds = secs;
    r.stamp.millis_in    = ms;
    r.typed              = 1'b1;
    r.want               = want;
    return r;
  endfunction

  function automatic stamp_row_t checked_row(input logic [31:0] secs, input logic [9:0] ms);
    stamp_row_t r;
    r.stamp.unix_seconds = secs;
    r.stamp.millis_in    = ms;
    r.typed              = 1'b0;
    r.want               = '0;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // random timestamps
  // ------------------------------------------------------------------------

  // half the draws are uniform over all 32 bits; the rest land near the
  // start of a random month of a random year, either within a few seconds
  // or within two days, so year rollovers and leap days are hit often
  function automatic in_t random_stamp();
    in_t               s;
    int unsigned       yr;
    int unsigned       mon;
    int unsigned       pick;
    longint unsigned   day0;
    longint            t;
    s.unix_seconds = $urandom;
    s.millis_in    = 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 3);
    if (pick >= 2) begin
      yr   = $urandom_range(EPOCH_YEAR, LAST_YEAR);
      mon  = $urandom_range(1, 12);
      day0 = 0;
      for (int unsigned y = EPOCH_YEAR; y < yr; y++) day0 += 64'(days_in_year(y));
      for (int unsigned m = 1; m < mon; m++) day0 += 64'(days_in_month(yr, m));
      t = longint'(day0 * SECONDS_PER_DAY);
      if (pick == 2) t = t + longint'($urandom_range(0, 8)) - 4;
      else t = t + longint'($urandom_range(0, 4 * SECONDS_PER_DAY)) - 2 * SECONDS_PER_DAY;
      // anything past the 32-bit range keeps the uniform draw
      if (t >= 0 && t < (longint'(1) << 32)) s.unix_seconds = 32'(t);
    end
    return s;
  endfunction

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
  endtask

  // one process sees both channels: a result is matched against the oldest
  // owed date, and an accepted transaction queues its date. everything read
  // here was set by nonblocking assignments, so the values are the ones
  // that stood before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_dates.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: %p", out_data));
        end else begin
          oldest_date = pending_dates.pop_front();
          check_field("cal_year",   32'(out_data.cal_year),   32'(oldest_date.cal_year));
          check_field("cal_month",  32'(out_data.cal_month),  32'(oldest_date.cal_month));
          check_field("cal_day",    32'(out_data.cal_day),    32'(oldest_date.cal_day));
          check_field("cal_hour",   32'(out_data.cal_hour),   32'(oldest_date.cal_hour));
          check_field("cal_minute", 32'(out_data.cal_minute), 32'(oldest_date.cal_minute));
          check_field("cal_second", 32'(out_data.cal_second), 32'(oldest_date.cal_second));
          check_field("millis_out", 32'(out_data.millis_out), 32'(oldest_date.millis_out));
        end
      end
      if (start && !busy)
        pending_dates.push_back(stim_typed ? stim_want : civil_date_of(in_data));

      // watchdog: any transaction on either side counts as progress
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // driving
  // ------------------------------------------------------------------------

  // called just after a rising edge; returns just after the edge that took
  // the transaction. busy only moves at rising edges, so reading it at the
  // falling edge tells whether the next rising edge accepts
  task automatic send_stamp(input in_t stamp, input bit typed, input out_t want);
    in_data    <= stamp;
    stim_typed <= typed;
    stim_want  <= want;
    start      <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // sender idles each cycle with the given chance, so about pct of the
  // cycles of a phase carry no transaction
  task automatic sender_gap(input int pct);
    while ($urandom_range(1, 100) <= pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off until every owed date has come back; always waits for a rising
  // edge first so start is not lowered and raised in the same step
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  initial begin
    // hand-typed rows: epoch, the last 32-bit second, millisecond saturation
    directed_rows.push_back(typed_row(32'd0,          10'd0,    civil(1970, 1, 1, 0, 0, 0, 0)));
    directed_rows.push_back(typed_row(32'hFFFF_FFFF,  10'd999,
                                      civil(2106, 2, 7, 6, 28, 15, 999)));
    directed_rows.push_back(typed_row(32'd86399,      10'd1000,
                                      civil(1970, 1, 1, 23, 59, 59, 999)));
    directed_rows.push_back(typed_row(32'd86400,      10'd1023, civil(1970, 1, 2, 0, 0, 0, 999)));
    directed_rows.push_back(typed_row(32'd0,          10'd1,    civil(1970, 1, 1, 0, 0, 0, 1)));
    // leap day in 1972, both sides of it
    directed_rows.push_back(checked_row(32'd68169599,   10'd500));
    directed_rows.push_back(checked_row(32'd68169600,   10'd0));
    directed_rows.push_back(checked_row(32'd68256000,   10'd3));
    // millennium rollover and the 2000 leap day (century divisible by 400)
    directed_rows.push_back(checked_row(32'd946684799,  10'd998));
    directed_rows.push_back(checked_row(32'd946684800,  10'd0));
    directed_rows.push_back(checked_row(32'd951782400,  10'd250));
    directed_rows.push_back(checked_row(32'd951868800,  10'd750));
    // 2100 is a century not divisible by 400: february has 28 days
    directed_rows.push_back(checked_row(32'd4102444799, 10'd999));
    directed_rows.push_back(checked_row(32'd4102444800, 10'd0));
    directed_rows.push_back(checked_row(32'd4107542399, 10'd1001));
    directed_rows.push_back(checked_row(32'd4107542400, 10'd0));
    // top bit of the seconds, and the last new year within range
    directed_rows.push_back(checked_row(32'd2147483647, 10'd511));
    directed_rows.push_back(checked_row(32'd2147483648, 10'd512));
    directed_rows.push_back(checked_row(32'd4291747200, 10'd0));
    // alternating bit patterns on both fields
    directed_rows.push_back(checked_row(32'hAAAA_AAAA,  10'h2AA));
    directed_rows.push_back(checked_row(32'h5555_5555,  10'h155));
    directed_rows.push_back(checked_row(32'd1234567890, 10'd1022));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, back to back
    foreach (directed_rows[i])
      send_stamp(directed_rows[i].stamp, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    // random phases, each with its own sender idle rate
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_stamp(random_stamp(), 1'b0, '0);
        sender_gap(phase_idle_pct[p]);
      end
      wait_drained();
    end

    // let anything stray come out before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
